### hw/rtl/assert_macros.svh
// Assertion macros of the port binding table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define PBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pbt_pkg.sv
// Shared types and constants of the port binding table.
package pbt_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam logic [31:0] EXPIRE_RST    = 32'd600;
  localparam logic [15:0] BASE_PORT_RST = 16'd8081;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  localparam logic [2:0] STAT_REFRESHED = 3'd0;
  localparam logic [2:0] STAT_ALLOCATED = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_EXPIRED   = 3'd3;
  localparam logic [2:0] STAT_DONE      = 3'd4;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic REG_EXPIRE = 1'b0;
  localparam logic REG_BASE   = 1'b1;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] stamp;
  } slot_rec_t;

  typedef struct packed {
    logic [31:0] expire_seconds;
    logic [15:0] base_port;
  } cfg_t;

endpackage

### hw/rtl/pbt_if.sv
// Request and result channel interfaces of the port binding table.
interface pbt_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] client_address;
  logic [31:0] current_time;

  modport source(output valid, mode, client_address, current_time, input ready);
  modport sink(input valid, mode, client_address, current_time, output ready);
endinterface

interface pbt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] port_number;
  logic [31:0] entry_address;
  logic [3:0]  slot_index;
  logic        last;

  modport source(output valid, status, port_number, entry_address, slot_index, last,
                 input ready);
  modport sink(input valid, status, port_number, entry_address, slot_index, last,
               output ready);
endinterface

### hw/rtl/pbt_mem.sv
// Slot memory: client address and time stamp per slot, registered read.
module pbt_mem #(
  parameter int DEPTH = pbt_pkg::ENTRIES_DEF,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  pbt_pkg::slot_rec_t  wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output pbt_pkg::slot_rec_t  rdata
);

  pbt_pkg::slot_rec_t mem [DEPTH];
  pbt_pkg::slot_rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/pbt_engine.sv
// Slot walker: read-modify-write sequencer over the slot memory, valid bits, result register.
`include "assert_macros.svh"

module pbt_engine #(
  parameter int ENTRIES = pbt_pkg::ENTRIES_DEF,
  parameter int IDX_W   = 4,
  parameter int CNT_W   = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pbt_pkg::cfg_t      cfg,
  pbt_in_if.sink             in_chan,
  pbt_out_if.source          out_chan,
  output logic               mem_we,
  output logic [IDX_W-1:0]   mem_waddr,
  output pbt_pkg::slot_rec_t mem_wdata,
  output logic               mem_re,
  output logic [IDX_W-1:0]   mem_raddr,
  input  pbt_pkg::slot_rec_t mem_rdata
);

  pbt_pkg::state_t state_r, state_nxt;

  logic              mode_r;
  logic [31:0]       addr_r;
  logic [31:0]       now_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic              ev_vld_r;
  logic [IDX_W-1:0]  ev_idx_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [ENTRIES-1:0] valid_r;

  logic        out_vld_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_port_r;
  logic [31:0] out_addr_r;
  logic [3:0]  out_slot_r;
  logic        out_last_r;

  logic        in_ready;
  logic        issue;
  logic        out_room;
  logic        ev_valid_bit;
  logic        hit;
  logic        expired;
  logic [31:0] age;
  logic        need_out;
  logic        stall;
  logic        advance;
  logic        out_load;
  logic        clear_valid;
  logic        set_valid;
  logic [2:0]  status_nxt;
  logic [15:0] port_nxt;
  logic [31:0] addr_nxt;
  logic [3:0]  slot_nxt;
  logic        last_nxt;

  assign issue        = (rd_idx_r != CNT_W'(ENTRIES));
  assign out_room     = !out_vld_r || out_chan.ready;
  assign ev_valid_bit = valid_r[ev_idx_r];
  assign age          = now_r - mem_rdata.stamp;
  assign hit          = ev_vld_r && ev_valid_bit && (mem_rdata.address == addr_r);
  assign expired      = ev_vld_r && ev_valid_bit && (age > cfg.expire_seconds);
  assign need_out     = (mode_r == pbt_pkg::MODE_TICK) ? expired : hit;
  assign stall        = need_out && !out_room;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbt_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = pbt_pkg::ST_SCAN;
        end
      end
      pbt_pkg::ST_SCAN: begin
        if (mode_r == pbt_pkg::MODE_ADD && hit && !stall) begin
          state_nxt = pbt_pkg::ST_IDLE;
        end else if (!ev_vld_r && !issue) begin
          state_nxt = pbt_pkg::ST_FIN;
        end
      end
      pbt_pkg::ST_FIN: begin
        if (out_room) begin
          state_nxt = pbt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pbt_pkg::ST_IDLE;
    endcase
  end

  // Controls and result word
  always_comb begin
    in_ready    = 1'b0;
    advance     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = ev_idx_r;
    mem_wdata   = '{address: addr_r, stamp: now_r};
    out_load    = 1'b0;
    clear_valid = 1'b0;
    set_valid   = 1'b0;
    status_nxt  = pbt_pkg::STAT_DONE;
    port_nxt    = cfg.base_port + 16'(ev_idx_r);
    addr_nxt    = addr_r;
    slot_nxt    = 4'(ev_idx_r);
    last_nxt    = 1'b1;
    unique case (state_r)
      pbt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      pbt_pkg::ST_SCAN: begin
        advance = !stall;
        if (!stall && need_out) begin
          out_load = 1'b1;
          case (mode_r)
            pbt_pkg::MODE_TICK: begin
              status_nxt  = pbt_pkg::STAT_EXPIRED;
              addr_nxt    = mem_rdata.address;
              last_nxt    = 1'b0;
              clear_valid = 1'b1;
            end
            default: begin
              status_nxt = pbt_pkg::STAT_REFRESHED;
              mem_we     = 1'b1;
            end
          endcase
        end
      end
      pbt_pkg::ST_FIN: begin
        if (out_room) begin
          out_load = 1'b1;
          if (mode_r == pbt_pkg::MODE_TICK) begin
            status_nxt = pbt_pkg::STAT_DONE;
            port_nxt   = '0;
            addr_nxt   = '0;
            slot_nxt   = '0;
          end else if (free_found_r) begin
            status_nxt = pbt_pkg::STAT_ALLOCATED;
            port_nxt   = cfg.base_port + 16'(free_idx_r);
            slot_nxt   = 4'(free_idx_r);
            mem_we     = 1'b1;
            mem_waddr  = free_idx_r;
            set_valid  = 1'b1;
          end else begin
            status_nxt = pbt_pkg::STAT_FULL;
            port_nxt   = '0;
            slot_nxt   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign mem_re    = advance && issue;
  assign mem_raddr = rd_idx_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pbt_pkg::ST_IDLE;
      rd_idx_r     <= '0;
      ev_vld_r     <= 1'b0;
      free_found_r <= 1'b0;
      valid_r      <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_chan.valid && in_ready) begin
        rd_idx_r     <= '0;
        ev_vld_r     <= 1'b0;
        free_found_r <= 1'b0;
      end
      // advance the read pipeline one slot
      if (advance) begin
        ev_vld_r <= issue;
        if (issue) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
        if (ev_vld_r && mode_r == pbt_pkg::MODE_ADD && !ev_valid_bit && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
      if (clear_valid) begin
        valid_r[ev_idx_r] <= 1'b0;
      end
      if (set_valid) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_ready) begin
      mode_r <= in_chan.mode;
      addr_r <= in_chan.client_address;
      now_r  <= in_chan.current_time;
    end
    if (advance) begin
      ev_idx_r <= rd_idx_r[IDX_W-1:0];
      // hold the lowest free slot seen so far
      if (ev_vld_r && mode_r == pbt_pkg::MODE_ADD && !ev_valid_bit && !free_found_r) begin
        free_idx_r <= ev_idx_r;
      end
    end
    if (out_load) begin
      out_status_r <= status_nxt;
      out_port_r   <= port_nxt;
      out_addr_r   <= addr_nxt;
      out_slot_r   <= slot_nxt;
      out_last_r   <= last_nxt;
    end
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_vld_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.port_number   = out_port_r;
  assign out_chan.entry_address = out_addr_r;
  assign out_chan.slot_index    = out_slot_r;
  assign out_chan.last          = out_last_r;

  `PBT_ASSERT(a_no_overwrite, out_load |-> (!out_vld_r || out_chan.ready), "result word overwritten")
  `PBT_ASSERT(a_last_only_expired, (out_vld_r && !out_last_r) |-> (out_status_r == pbt_pkg::STAT_EXPIRED), "non-final word with wrong status")
  `PBT_ASSERT(a_tick_no_write, mem_we |-> (mode_r == pbt_pkg::MODE_ADD), "tick wrote slot memory")
  `PBT_ASSERT(a_fin_after_walk, (state_r == pbt_pkg::ST_FIN) |-> (rd_idx_r == CNT_W'(ENTRIES) && !ev_vld_r), "finish before walk ended")
  `PBT_ASSERT_NEXT(a_alloc_valid, set_valid, valid_r[$past(free_idx_r)], "allocated slot not valid")

endmodule

### hw/rtl/port_binding_table_with_aging_core.sv
// Top level of the port binding table with aging: APB registers, slot memory, walker.
//
// An add word walks every slot unless a refresh hits, which ends its walk early; a tick
// word walks every slot. Either kind waits while the result side stalls. The walker reads
// one slot of the slot memory per cycle through its single read port while the result
// side does not stall it. A new word is accepted once the previous one has placed its
// last result in the output register. Valid bits live in flip-flops cleared by reset,
// so no clearing pass runs.
module port_binding_table_with_aging_core #(
  parameter int ENTRIES = pbt_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pbt_in_if.sink      in_chan,
  pbt_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  pbt_pkg::cfg_t      cfg_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  pbt_pkg::slot_rec_t mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  pbt_pkg::slot_rec_t mem_rdata;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expire_seconds <= pbt_pkg::EXPIRE_RST;
      cfg_r.base_port      <= pbt_pkg::BASE_PORT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        pbt_pkg::REG_EXPIRE: cfg_r.expire_seconds <= pwdata;
        pbt_pkg::REG_BASE:   cfg_r.base_port      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pbt_pkg::REG_EXPIRE: prdata = cfg_r.expire_seconds;
      pbt_pkg::REG_BASE:   prdata = {16'd0, cfg_r.base_port};
      default:             prdata = '0;
    endcase
  end

  pbt_mem #(
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pbt_engine #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

### tb/port_binding_table_with_aging_checker.sv
// Checker of the port binding table: predicts result words from requests and compares them.
module port_binding_table_with_aging_checker #(
  parameter int SLOTS = pbt_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pbt_in_if           req_mon,
  pbt_out_if          rsp_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] port_number;
    logic [31:0] entry_address;
    logic [3:0]  slot_index;
    logic        last;
  } binding_result_t;

  logic            bound [SLOTS];
  logic [31:0]     bound_addr [SLOTS];
  logic [31:0]     bound_stamp [SLOTS];
  logic [31:0]     expire_limit;
  logic [15:0]     port_base;
  binding_result_t expected_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic binding_result_t make_result(logic [2:0] status, logic [15:0] port,
                                                  logic [31:0] addr, int slot, logic last);
    binding_result_t r;
    r.status        = status;
    r.port_number   = port;
    r.entry_address = addr;
    r.slot_index    = 4'(slot);
    r.last          = last;
    return r;
  endfunction

  // Apply one request word to the binding table copy and queue the words it causes.
  task automatic predict_bindings(input logic mode, input logic [31:0] addr,
                                  input logic [31:0] now);
    int          hit;
    int          free_slot;
    logic [31:0] age;
    hit       = -1;
    free_slot = -1;
    if (mode == pbt_pkg::MODE_ADD) begin
      for (int i = 0; i < SLOTS; i++)
        if (hit < 0 && bound[i] && bound_addr[i] == addr) hit = i;
      if (hit >= 0) begin
        bound_stamp[hit] = now;
        expected_q.push_back(make_result(pbt_pkg::STAT_REFRESHED, port_base + 16'(hit), addr,
                                         hit, 1'b1));
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (free_slot < 0 && !bound[i]) free_slot = i;
        if (free_slot >= 0) begin
          bound[free_slot]       = 1'b1;
          bound_addr[free_slot]  = addr;
          bound_stamp[free_slot] = now;
          expected_q.push_back(make_result(pbt_pkg::STAT_ALLOCATED, port_base + 16'(free_slot),
                                           addr, free_slot, 1'b1));
        end else begin
          expected_q.push_back(make_result(pbt_pkg::STAT_FULL, 16'd0, addr, 0, 1'b1));
        end
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        age = now - bound_stamp[i];
        if (bound[i] && age > expire_limit) begin
          expected_q.push_back(make_result(pbt_pkg::STAT_EXPIRED, port_base + 16'(i),
                                           bound_addr[i], i, 1'b0));
          bound[i] = 1'b0;
        end
      end
      expected_q.push_back(make_result(pbt_pkg::STAT_DONE, 16'd0, 32'd0, 0, 1'b1));
    end
  endtask

  always @(posedge clk) begin : watch
    binding_result_t got;
    binding_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) bound[i] = 1'b0;
      expire_limit = pbt_pkg::EXPIRE_RST;
      port_base    = pbt_pkg::BASE_PORT_RST;
      expected_q.delete();
    end else begin
      // Pop before push: a result word never belongs to a request taken at the same edge.
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status        = rsp_mon.status;
        got.port_number   = rsp_mon.port_number;
        got.entry_address = rsp_mon.entry_address;
        got.slot_index    = rsp_mon.slot_index;
        got.last          = rsp_mon.last;
        checked++;
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word: status %0d port %0d addr %h slot %0d last %0d",
                   $time, got.status, got.port_number, got.entry_address, got.slot_index,
                   got.last);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: result mismatch: expected status %0d port %0d addr %h slot %0d last %0d",
                     $time, want.status, want.port_number, want.entry_address, want.slot_index,
                     want.last);
            $display("%0t:                  actual status %0d port %0d addr %h slot %0d last %0d",
                     $time, got.status, got.port_number, got.entry_address, got.slot_index,
                     got.last);
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        predict_bindings(req_mon.mode, req_mon.client_address, req_mon.current_time);
      if (psel && penable && pready && pwrite) begin
        if (paddr[2] == pbt_pkg::REG_EXPIRE) expire_limit = pwdata;
        else port_base = pwdata[15:0];
      end
      if (psel && penable && pready && !pwrite) begin
        if (paddr[2] == pbt_pkg::REG_EXPIRE && prdata !== expire_limit) begin
          fail_count++;
          $display("%0t: expiry register read: expected %h actual %h", $time, expire_limit,
                   prdata);
        end
        if (paddr[2] == pbt_pkg::REG_BASE && prdata[15:0] !== port_base) begin
          fail_count++;
          $display("%0t: port base register read: expected %h actual %h", $time, port_base,
                   prdata[15:0]);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### tb/port_binding_table_with_aging_core_test.sv
// Top of the port binding table test: clock, reset, request and register stimulus, verdict.
module port_binding_table_with_aging_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS  = pbt_pkg::ENTRIES_DEF;
  localparam int SETTLE = SLOTS + 8;
  localparam int POOL   = 24;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          checked;
  int          send_idle_pct;
  int          stall_pct;
  int          words_sent;
  int          ticks_sent;
  int          cfg_writes;
  logic [31:0] clock_s;
  logic [31:0] addr_pool [POOL];

  pbt_in_if  req_if ();
  pbt_out_if rsp_if ();

  port_binding_table_with_aging_core #(.ENTRIES(SLOTS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  port_binding_table_with_aging_checker #(.SLOTS(SLOTS)) binding_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_if),
    .rsp_mon    (rsp_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: stall at random with the current phase's rate.
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(input logic mode, input logic [31:0] addr, input logic [31:0] now);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid          = 1'b0;
      req_if.mode           = 1'($urandom);
      req_if.client_address = $urandom;
      req_if.current_time   = $urandom;
      @(negedge clk);
    end
    req_if.valid          = 1'b1;
    req_if.mode           = mode;
    req_if.client_address = addr;
    req_if.current_time   = now;
    do @(posedge clk); while (!req_if.ready);
    words_sent++;
    if (mode == pbt_pkg::MODE_TICK) ticks_sent++;
  endtask

  // Hold the sender until every expected word has come back.
  task automatic hold_for_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    wait (pending == 0);
  endtask

  task automatic reg_access(input logic wr, input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (wr) cfg_writes++;
  endtask

  task automatic run_phase(input logic [31:0] expire, input logic [31:0] base, input int idle,
                           input int stall, input int count, input int unsigned step_max,
                           input int pressure_at);
    logic        mode;
    logic [31:0] addr;
    hold_for_results();
    repeat (SETTLE) @(negedge clk);
    reg_access(1'b1, pbt_pkg::REG_EXPIRE, expire);
    reg_access(1'b1, pbt_pkg::REG_BASE, base);
    reg_access(1'b0, pbt_pkg::REG_EXPIRE, 32'd0);
    reg_access(1'b0, pbt_pkg::REG_BASE, 32'd0);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int k = 0; k < POOL; k++) addr_pool[k] = $urandom;
    for (int n = 0; n < count; n++) begin
      mode = ($urandom_range(99) < 25) ? pbt_pkg::MODE_TICK : pbt_pkg::MODE_ADD;
      if ($urandom_range(99) < 5) clock_s = $urandom;
      else clock_s = clock_s + $urandom_range(step_max);
      addr = ($urandom_range(99) < 80) ? addr_pool[$urandom_range(POOL - 1)] : $urandom;
      send_word(mode, addr, clock_s);
      if (n == pressure_at) hold_for_results();
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    req_if.valid          = 1'b0;
    req_if.mode           = pbt_pkg::MODE_ADD;
    req_if.client_address = '0;
    req_if.current_time   = '0;
    rsp_if.ready          = 1'b0;
    send_idle_pct         = 0;
    stall_pct             = 0;
    words_sent            = 0;
    ticks_sent            = 0;
    cfg_writes            = 0;
    clock_s               = 32'd1000;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset values of both registers.
    reg_access(1'b0, pbt_pkg::REG_EXPIRE, 32'd0);
    reg_access(1'b0, pbt_pkg::REG_BASE, 32'd0);

    // Stamp of zero, all-ones address, refresh, and an age that wraps past zero.
    send_word(pbt_pkg::MODE_ADD, 32'h0000_0000, 32'h0000_0000);
    send_word(pbt_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(pbt_pkg::MODE_ADD, 32'h0000_0000, 32'd5);
    send_word(pbt_pkg::MODE_TICK, 32'h0000_0000, 32'd605);
    send_word(pbt_pkg::MODE_TICK, 32'hFFFF_FFFF, 32'd606);
    // Fill every slot, overflow, refresh the last slot, then age all of them out at once.
    for (int k = 0; k < SLOTS; k++) send_word(pbt_pkg::MODE_ADD, 32'h0A00_0000 + k, 32'd100);
    send_word(pbt_pkg::MODE_ADD, 32'hC0A8_0001, 32'd150);
    send_word(pbt_pkg::MODE_ADD, 32'h0A00_0000 + SLOTS - 1, 32'd200);
    send_word(pbt_pkg::MODE_TICK, 32'h5555_AAAA, 32'hFFFF_FFFF);
    hold_for_results();

    run_phase(32'd0, {16'hA5C3, 16'hFFF8}, 0, 0, 46, 3, -1);
    run_phase(32'hFFFF_FFFF, 32'd0, 58, 0, 46, 1000, -1);
    run_phase($urandom_range(200, 1), $urandom, 0, 58, 46, 100, 23);
    run_phase(32'd600, 32'd8081, 17, 17, 46, 300, -1);
    run_phase($urandom, 32'h0000_FFFF, 0, 0, 46, 32'hFFFF_FFFF, 20);
    run_phase($urandom_range(80, 20), $urandom, 58, 58, 46, 60, -1);

    hold_for_results();
    repeat (4 * SETTLE) @(negedge clk);
    $display("Run covered %0d request words (%0d aging ticks), %0d result words, %0d writes.",
             words_sent, ticks_sent, checked, cfg_writes);
    $display("Expiry limits from zero to all ones, port base wrap, full table, gaps and stalls.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
